### rtl/hbridge_slew_limited_drive_unit_defines.svh
// ----------------------------------------------------------------------------
// H-bridge drive assertion macros
// Shared assertion forms for the slew-limited H-bridge drive.
// ----------------------------------------------------------------------------
`ifndef HBRIDGE_SLEW_LIMITED_DRIVE_UNIT_DEFINES_SVH
`define HBRIDGE_SLEW_LIMITED_DRIVE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HBSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/hbsd_pkg.sv
// ----------------------------------------------------------------------------
// H-bridge drive package
// Types and constants shared by the slew-limited H-bridge drive modules.
// ----------------------------------------------------------------------------
package hbsd_pkg;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_COMMAND   = 3'd1;
  localparam logic [2:0] CMD_DISENGAGE = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_STOP_PORT = 3'd4;
  localparam logic [2:0] CMD_STOP_STBD = 3'd5;

  localparam logic [1:0] REG_FAST_STEP    = 2'd0;
  localparam logic [1:0] REG_SLOW_STEP    = 2'd1;
  localparam logic [1:0] REG_NEUTRAL_BAND = 2'd2;

  localparam logic [10:0] NEUTRAL_POS  = 11'd1000;
  localparam logic [15:0] FULL_SCALE   = 16'd2000;
  localparam logic [15:0] NEUTRAL_TGT  = 16'd1000;

  localparam logic [7:0] TICKS_DISENGAGE       = 8'd120;
  localparam logic [7:0] TICKS_DETACH          = 8'd128;
  localparam logic [7:0] TICKS_AFTER_DISENGAGE = 8'd60;
  localparam logic [7:0] TICKS_AFTER_DETACH    = 8'd80;

  localparam logic [7:0] STEP_MIN      = 8'd1;
  localparam logic [7:0] STEP_MAX      = 8'd250;
  localparam logic [7:0] STEP_RESET    = 8'd20;
  localparam logic [9:0] BAND_RESET    = 10'd10;

  typedef struct packed {
    logic [7:0] fast_step;
    logic [7:0] slow_step;
    logic [9:0] neutral_band;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] target;
    logic        block_fault;
    logic        port_fault;
    logic        starboard_fault;
  } item_t;

  typedef struct packed {
    logic [12:0] right_duty;
    logic [12:0] left_duty;
    logic        bridge_enable;
    logic        is_engaged;
    logic [10:0] present_position;
  } res_t;

endpackage

### rtl/hbsd_cfg.sv
// ----------------------------------------------------------------------------
// H-bridge drive configuration registers
// Holds the step limits and neutral band, clamping the step limits on write.
// ----------------------------------------------------------------------------
module hbsd_cfg import hbsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_addr,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [7:0] step_clamped;

  always_comb begin
    if (wr_data[7:0] < STEP_MIN) begin
      step_clamped = STEP_MIN;
    end else if (wr_data[7:0] > STEP_MAX) begin
      step_clamped = STEP_MAX;
    end else begin
      step_clamped = wr_data[7:0];
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_addr)
        REG_FAST_STEP:    cfg_nxt.fast_step    = step_clamped;
        REG_SLOW_STEP:    cfg_nxt.slow_step    = step_clamped;
        REG_NEUTRAL_BAND: cfg_nxt.neutral_band = wr_data[9:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_step    <= STEP_RESET;
      cfg_r.slow_step    <= STEP_RESET;
      cfg_r.neutral_band <= BAND_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/hbsd_core.sv
// ----------------------------------------------------------------------------
// H-bridge drive core
// Applies one word to the drive state and holds the resulting bridge outputs.
// ----------------------------------------------------------------------------
module hbsd_core import hbsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [10:0] goal_r, goal_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic        eng_r, eng_nxt;
  logic [7:0]  ticks_r, ticks_nxt;
  logic [12:0] right_r, right_nxt;
  logic [12:0] left_r, left_nxt;
  logic        en_r, en_nxt;

  logic        move_up;
  logic [7:0]  up_lim;
  logic [7:0]  dn_lim;
  logic [10:0] gap_up;
  logic [10:0] gap_dn;
  logic [10:0] step_pos;
  logic [25:0] step_duty;
  logic        cmd_ok;
  logic        cmd_blocked;

  function automatic logic [25:0] duty_of(input logic [10:0] p, input logic [9:0] band);
    logic [10:0] offset;
    logic [12:0] duty;
    logic        above;
    logic        below;
    offset = (p >= NEUTRAL_POS) ? (p - NEUTRAL_POS) : (NEUTRAL_POS - p);
    duty   = {offset, 2'b00} + {2'b00, offset};
    above  = {1'b0, p} > ({1'b0, NEUTRAL_POS} + {2'b00, band});
    below  = ({1'b0, p} + {2'b00, band}) < {1'b0, NEUTRAL_POS};
    if (above) begin
      duty_of = {duty, 13'd0};
    end else if (below) begin
      duty_of = {13'd0, duty};
    end else begin
      duty_of = 26'd0;
    end
  endfunction

  always_comb begin
    move_up  = goal_r > pos_r;
    up_lim   = (pos_r < NEUTRAL_POS) ? cfg.slow_step : cfg.fast_step;
    dn_lim   = (pos_r > NEUTRAL_POS) ? cfg.slow_step : cfg.fast_step;
    gap_up   = goal_r - pos_r;
    gap_dn   = pos_r - goal_r;
    if (move_up) begin
      step_pos = (gap_up > {3'b000, up_lim}) ? (pos_r + {3'b000, up_lim}) : goal_r;
    end else begin
      step_pos = (gap_dn > {3'b000, dn_lim}) ? (pos_r - {3'b000, dn_lim}) : goal_r;
    end
    step_duty = duty_of(step_pos, cfg.neutral_band);
  end

  assign cmd_ok      = (item.target <= FULL_SCALE) && !item.block_fault;
  assign cmd_blocked = (item.port_fault && (item.target > NEUTRAL_TGT)) ||
                       (item.starboard_fault && (item.target < NEUTRAL_TGT));

  always_comb begin
    goal_nxt  = goal_r;
    pos_nxt   = pos_r;
    eng_nxt   = eng_r;
    ticks_nxt = ticks_r;
    right_nxt = right_r;
    left_nxt  = left_r;
    en_nxt    = en_r;
    case (item.cmd)
      CMD_TICK: begin
        if (eng_r) begin
          pos_nxt   = step_pos;
          right_nxt = step_duty[25:13];
          left_nxt  = step_duty[12:0];
        end
        ticks_nxt = ticks_r + 8'd1;
        if (ticks_nxt == TICKS_DISENGAGE) begin
          pos_nxt   = NEUTRAL_POS;
          goal_nxt  = NEUTRAL_POS;
          right_nxt = '0;
          left_nxt  = '0;
          eng_nxt   = 1'b0;
          ticks_nxt = TICKS_AFTER_DISENGAGE;
        end
        if (ticks_nxt >= TICKS_DETACH) begin
          right_nxt = '0;
          left_nxt  = '0;
          en_nxt    = 1'b0;
          ticks_nxt = TICKS_AFTER_DETACH;
        end
      end
      CMD_COMMAND: begin
        ticks_nxt = '0;
        if (cmd_ok) begin
          if (cmd_blocked) begin
            pos_nxt   = NEUTRAL_POS;
            goal_nxt  = NEUTRAL_POS;
            right_nxt = '0;
            left_nxt  = '0;
          end else begin
            goal_nxt = item.target[10:0];
            if (!eng_r) begin
              right_nxt = '0;
              left_nxt  = '0;
              en_nxt    = 1'b1;
              eng_nxt   = 1'b1;
            end
          end
        end
      end
      CMD_DISENGAGE: begin
        pos_nxt   = NEUTRAL_POS;
        goal_nxt  = NEUTRAL_POS;
        right_nxt = '0;
        left_nxt  = '0;
        eng_nxt   = 1'b0;
        ticks_nxt = TICKS_AFTER_DISENGAGE;
      end
      CMD_STOP: begin
        pos_nxt   = NEUTRAL_POS;
        goal_nxt  = NEUTRAL_POS;
        right_nxt = '0;
        left_nxt  = '0;
      end
      CMD_STOP_PORT: begin
        if (pos_r > NEUTRAL_POS) begin
          pos_nxt   = NEUTRAL_POS;
          goal_nxt  = NEUTRAL_POS;
          right_nxt = '0;
          left_nxt  = '0;
        end
      end
      CMD_STOP_STBD: begin
        if (pos_r < NEUTRAL_POS) begin
          pos_nxt   = NEUTRAL_POS;
          goal_nxt  = NEUTRAL_POS;
          right_nxt = '0;
          left_nxt  = '0;
        end
      end
      default: begin
        goal_nxt = goal_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r  <= NEUTRAL_POS;
      pos_r   <= NEUTRAL_POS;
      eng_r   <= 1'b0;
      ticks_r <= '0;
      right_r <= '0;
      left_r  <= '0;
      en_r    <= 1'b1;
    end else if (step_en) begin
      goal_r  <= goal_nxt;
      pos_r   <= pos_nxt;
      eng_r   <= eng_nxt;
      ticks_r <= ticks_nxt;
      right_r <= right_nxt;
      left_r  <= left_nxt;
      en_r    <= en_nxt;
    end
  end

  assign res.right_duty       = right_r;
  assign res.left_duty        = left_r;
  assign res.bridge_enable    = en_r;
  assign res.is_engaged       = eng_r;
  assign res.present_position = pos_r;

endmodule

### rtl/hbridge_slew_limited_drive_unit.sv
// ----------------------------------------------------------------------------
// Slew-limited H-bridge drive
// The block takes one word per clock while out_stall does not hold it off, and
// returns one result word for each: the word is held in the input register,
// then it updates the drive state, whose registers also hold the result word.
// The sustained rate is one word per cycle when the output is not stalled.
// Configuration writes are always ready and take effect on the next word.
// ----------------------------------------------------------------------------
`include "hbridge_slew_limited_drive_unit_defines.svh"

module hbridge_slew_limited_drive_unit import hbsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_target,
  input  logic        in_block_fault,
  input  logic        in_port_fault,
  input  logic        in_starboard_fault,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_right_duty,
  output logic [12:0] out_left_duty,
  output logic        out_bridge_enable,
  output logic        out_is_engaged,
  output logic [10:0] out_present_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic  in_valid_r, in_valid_nxt;
  logic  out_valid_r, out_valid_nxt;
  item_t item_r;
  logic  in_take;
  logic  step_en;
  cfg_t  cfg;
  res_t  res;

  assign cfg_ready = 1'b1;
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign step_en   = in_valid_r && !(out_valid_r && out_stall);

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd             <= in_cmd;
      item_r.target          <= in_target;
      item_r.block_fault     <= in_block_fault;
      item_r.port_fault      <= in_port_fault;
      item_r.starboard_fault <= in_starboard_fault;
    end
  end

  hbsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_wdata),
    .cfg     (cfg)
  );

  hbsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_valid            = out_valid_r;
  assign out_right_duty       = res.right_duty;
  assign out_left_duty        = res.left_duty;
  assign out_bridge_enable    = res.bridge_enable;
  assign out_is_engaged       = res.is_engaged;
  assign out_present_position = res.present_position;

  `HBSD_ASSERT_NOW(a_right_above, out_right_duty != 13'd0, out_present_position > NEUTRAL_POS)
  `HBSD_ASSERT_NOW(a_left_below, out_left_duty != 13'd0, out_present_position < NEUTRAL_POS)
  `HBSD_ASSERT_NOW(a_idle_neutral, !out_is_engaged, out_present_position == NEUTRAL_POS)
  `HBSD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  `HBSD_ASSERT_NEXT(a_stop_neutral, step_en && item_r.cmd == CMD_STOP, out_present_position == NEUTRAL_POS && out_right_duty == 13'd0 && out_left_duty == 13'd0)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew-limited H-bridge drive testbench
// Drives command, tick, stop and disengage words into the drive, with random
// gaps and stalls on both channels, and compares every result word against
// a cycle-free model of the drive state kept in the testbench. A directed
// table comes first, then random traffic under three register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import hbsd_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam logic [2:0] F_NONE  = 3'b000;
  localparam logic [2:0] F_BLOCK = 3'b100;
  localparam logic [2:0] F_PORT  = 3'b010;
  localparam logic [2:0] F_STBD  = 3'b001;

  localparam int NEUTRAL   = int'(NEUTRAL_POS);
  localparam int DUTY_GAIN = 5;
  localparam int N_DIR     = 25;
  localparam int PHASE_WORDS = 125;

  localparam res_t REST_OFF = '{13'd0, 13'd0, 1'b1, 1'b0, 11'd1000};
  localparam res_t REST_ON  = '{13'd0, 13'd0, 1'b1, 1'b1, 11'd1000};

  typedef struct {
    item_t word;
    bit    literal;
    res_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [15:0] in_target = '0;
  logic        in_block_fault = 1'b0;
  logic        in_port_fault = 1'b0;
  logic        in_starboard_fault = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] out_right_duty;
  logic [12:0] out_left_duty;
  logic        out_bridge_enable;
  logic        out_is_engaged;
  logic [10:0] out_present_position;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // Drive model state and settings.
  logic [7:0]  fast_lim = STEP_RESET;
  logic [7:0]  slow_lim = STEP_RESET;
  logic [9:0]  band_half = BAND_RESET;
  logic [10:0] goal_pos = NEUTRAL_POS;
  logic [10:0] applied_pos = NEUTRAL_POS;
  logic        engaged = 1'b0;
  logic [7:0]  idle_count = '0;
  logic [12:0] right_lvl = '0;
  logic [12:0] left_lvl = '0;
  logic        enables = 1'b1;

  res_t pending_results[$];
  int   mismatches = 0;
  int   results_checked = 0;
  int   words_sent = 0;
  int   backpressure_cycles = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   phase = 0;
  logic hold_active = 1'b0;
  dir_row_t dir_rows [N_DIR];

  hbridge_slew_limited_drive_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_target           (in_target),
    .in_block_fault      (in_block_fault),
    .in_port_fault       (in_port_fault),
    .in_starboard_fault  (in_starboard_fault),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_right_duty      (out_right_duty),
    .out_left_duty       (out_left_duty),
    .out_bridge_enable   (out_bridge_enable),
    .out_is_engaged      (out_is_engaged),
    .out_present_position(out_present_position),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void place_at(logic [10:0] pos);
    int p;
    int offset;
    p = int'(pos);
    offset = (p > NEUTRAL) ? p - NEUTRAL : NEUTRAL - p;
    applied_pos = pos;
    right_lvl = '0;
    left_lvl = '0;
    if (p > NEUTRAL + int'(band_half)) begin
      right_lvl = 13'(DUTY_GAIN * offset);
    end else if (p < NEUTRAL - int'(band_half)) begin
      left_lvl = 13'(DUTY_GAIN * offset);
    end
  endfunction

  function automatic void stop_drive();
    place_at(NEUTRAL_POS);
    goal_pos = NEUTRAL_POS;
  endfunction

  function automatic void disengage_drive();
    stop_drive();
    engaged = 1'b0;
    idle_count = TICKS_AFTER_DISENGAGE;
  endfunction

  function automatic void tick_drive();
    int cur;
    int diff;
    int lim;
    if (engaged) begin
      cur = int'(applied_pos);
      diff = int'(goal_pos) - cur;
      if (diff > 0) begin
        lim = (cur < NEUTRAL) ? int'(slow_lim) : int'(fast_lim);
        if (diff > lim) diff = lim;
      end else begin
        lim = (cur > NEUTRAL) ? int'(slow_lim) : int'(fast_lim);
        if (diff < -lim) diff = -lim;
      end
      place_at(11'(cur + diff));
    end
    idle_count = idle_count + 8'd1;
    if (idle_count == TICKS_DISENGAGE) disengage_drive();
    if (idle_count >= TICKS_DETACH) begin
      right_lvl = '0;
      left_lvl = '0;
      enables = 1'b0;
      idle_count = TICKS_AFTER_DETACH;
    end
  endfunction

  function automatic void command_drive(item_t w);
    idle_count = '0;
    if (w.target > FULL_SCALE || w.block_fault) begin
    end else if (w.port_fault && w.target > NEUTRAL_TGT) begin
      stop_drive();
    end else if (w.starboard_fault && w.target < NEUTRAL_TGT) begin
      stop_drive();
    end else begin
      goal_pos = w.target[10:0];
      if (!engaged) begin
        right_lvl = '0;
        left_lvl = '0;
        enables = 1'b1;
        engaged = 1'b1;
      end
    end
  endfunction

  function automatic res_t drive_next_result(item_t w);
    case (w.cmd)
      CMD_TICK:      tick_drive();
      CMD_COMMAND:   command_drive(w);
      CMD_DISENGAGE: disengage_drive();
      CMD_STOP:      stop_drive();
      CMD_STOP_PORT: if (applied_pos > NEUTRAL_POS) stop_drive();
      CMD_STOP_STBD: if (applied_pos < NEUTRAL_POS) stop_drive();
      default: begin
      end
    endcase
    return '{right_lvl, left_lvl, enables, engaged, applied_pos};
  endfunction

  function automatic logic [7:0] limit_step(logic [15:0] v);
    if (v[7:0] < STEP_MIN) return STEP_MIN;
    if (v[7:0] > STEP_MAX) return STEP_MAX;
    return v[7:0];
  endfunction

  function automatic dir_row_t dir_word(logic [2:0] cmd, logic [15:0] tgt, logic [2:0] f,
                                        bit lit, res_t want);
    dir_row_t r;
    r.word = '{cmd, tgt, f[2], f[1], f[0]};
    r.literal = lit;
    r.want = want;
    return r;
  endfunction

  function automatic logic [15:0] pick_target();
    int t;
    case ($urandom_range(0, 5))
      0: t = 0;
      1: t = int'(FULL_SCALE);
      2: t = NEUTRAL;
      3: t = (NEUTRAL + 1 + int'(band_half) > 2000) ? 2000 : NEUTRAL + 1 + int'(band_half);
      4: t = (band_half < 10'd1000) ? NEUTRAL - 1 - int'(band_half) : 0;
      default: t = $urandom_range(0, 2000);
    endcase
    return 16'(t);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // The caller stands at a rising edge; the previous word, if any, was taken there.
  task automatic send_word(item_t w, bit lit, res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= w.cmd;
    in_target <= w.target;
    in_block_fault <= w.block_fault;
    in_port_fault <= w.port_fault;
    in_starboard_fault <= w.starboard_fault;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = drive_next_result(w);
    pending_results.push_back(lit ? want : predicted);
    words_sent++;
  endtask

  task automatic offer(logic [2:0] cmd, logic [15:0] tgt, logic [2:0] f);
    send_word('{cmd, tgt, f[2], f[1], f[0]}, 1'b0, '0);
  endtask

  task automatic load_settings(logic [15:0] fast_w, logic [15:0] slow_w, logic [15:0] band_w);
    logic [15:0] vals [3];
    logic [1:0] regs [3];
    vals = '{fast_w, slow_w, band_w};
    regs = '{REG_FAST_STEP, REG_SLOW_STEP, REG_NEUTRAL_BAND};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr <= regs[i];
      cfg_wdata <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    fast_lim = limit_step(fast_w);
    slow_lim = limit_step(slow_w);
    band_half = band_w[9:0];
  endtask

  task automatic random_burst();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      offer(CMD_COMMAND, pick_target(), ($urandom_range(0, 4) == 0) ? 3'($urandom) : F_NONE);
      n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && $urandom_range(0, 4) == 0) offer(CMD_COMMAND, pick_target(), F_NONE);
        offer(CMD_TICK, 16'($urandom), 3'($urandom));
      end
    end else if (kind < 70) begin
      case ($urandom_range(0, 3))
        0: offer(CMD_STOP, 16'($urandom), 3'($urandom));
        1: offer(CMD_STOP_PORT, 16'($urandom), 3'($urandom));
        2: offer(CMD_STOP_STBD, 16'($urandom), 3'($urandom));
        default: offer(CMD_DISENGAGE, 16'($urandom), 3'($urandom));
      endcase
    end else if (kind < 88) begin
      offer(3'($urandom_range(0, 7)), 16'($urandom), 3'($urandom));
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        offer(CMD_COMMAND, 16'($urandom_range(2001, 65535)), 3'($urandom));
      end else begin
        offer(CMD_COMMAND, pick_target(), F_BLOCK | 3'($urandom));
      end
      offer(CMD_TICK, 16'($urandom), 3'($urandom));
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("right_duty", want.right_duty, out_right_duty);
        check_field("left_duty", want.left_duty, out_left_duty);
        check_field("bridge_enable", want.bridge_enable, out_bridge_enable);
        check_field("is_engaged", want.is_engaged, out_is_engaged);
        check_field("present_position", want.present_position, out_present_position);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
    if (in_valid && in_stall === 1'b1) backpressure_cycles++;
  end

  // Long receiver hold-off while the sender keeps offering words.
  initial begin : receiver_hold
    wait (phase == 3);
    repeat (20) @(posedge clk);
    hold_active <= 1'b1;
    repeat (64) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin : stimulus
    int phase_end;
    dir_rows = '{
      dir_word(CMD_TICK,      16'd0,     F_NONE,          1'b1, REST_OFF),
      dir_word(CMD_COMMAND,   16'hFFFF,  F_NONE,          1'b1, REST_OFF),
      dir_word(CMD_COMMAND,   16'd2001,  F_NONE,          1'b1, REST_OFF),
      dir_word(CMD_COMMAND,   16'd2000,  F_BLOCK,         1'b1, REST_OFF),
      dir_word(CMD_COMMAND,   16'd2000,  F_PORT,          1'b1, REST_OFF),
      dir_word(CMD_COMMAND,   16'd0,     F_STBD,          1'b1, REST_OFF),
      dir_word(CMD_COMMAND,   16'd2000,  F_NONE,          1'b1, REST_ON),
      dir_word(CMD_TICK,      16'd0,     F_NONE,          1'b0, '0),
      dir_word(CMD_TICK,      16'hFFFF,  F_BLOCK,         1'b0, '0),
      dir_word(CMD_STOP_STBD, 16'd0,     F_NONE,          1'b0, '0),
      dir_word(CMD_STOP_PORT, 16'd0,     F_NONE,          1'b1, REST_ON),
      dir_word(CMD_COMMAND,   16'd0,     F_PORT,          1'b0, '0),
      dir_word(CMD_TICK,      16'd0,     F_NONE,          1'b0, '0),
      dir_word(CMD_TICK,      16'd0,     F_NONE,          1'b0, '0),
      dir_word(CMD_STOP_PORT, 16'd0,     F_NONE,          1'b0, '0),
      dir_word(CMD_STOP_STBD, 16'd0,     F_NONE,          1'b1, REST_ON),
      dir_word(CMD_COMMAND,   16'd1000,  F_PORT | F_STBD, 1'b0, '0),
      dir_word(CMD_SPARE_A,   16'd0,     F_NONE,          1'b0, '0),
      dir_word(CMD_SPARE_B,   16'hFFFF,  3'b111,          1'b0, '0),
      dir_word(CMD_COMMAND,   16'd1500,  F_NONE,          1'b0, '0),
      dir_word(CMD_TICK,      16'd0,     F_NONE,          1'b0, '0),
      dir_word(CMD_STOP,      16'd0,     F_NONE,          1'b1, REST_ON),
      dir_word(CMD_DISENGAGE, 16'd0,     F_NONE,          1'b1, REST_OFF),
      dir_word(CMD_TICK,      16'd0,     F_NONE,          1'b1, REST_OFF),
      dir_word(CMD_COMMAND,   16'd2000,  3'b111,          1'b1, REST_OFF)
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++) send_word(dir_rows[i].word, dir_rows[i].literal,
                                              dir_rows[i].want);
    for (int ph = 1; ph <= 3; ph++) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      case (ph)
        1: load_settings(16'h0000, 16'h00FF, 16'd1000);
        2: load_settings(16'hFFFA, 16'hFF01, 16'hFC00);
        default: load_settings(16'($urandom), 16'($urandom), 16'h03FF);
      endcase
      send_gap_pct <= (ph == 1) ? 37 : (ph == 2) ? 76 : 0;
      recv_stall_pct <= (ph == 1) ? 76 : (ph == 2) ? 37 : 0;
      phase <= ph;
      phase_end = words_sent + PHASE_WORDS;
      if (ph != 2) begin
        offer(CMD_COMMAND, pick_target(), F_NONE);
        repeat ($urandom_range(120, 128)) offer(CMD_TICK, 16'($urandom), 3'($urandom));
      end
      while (words_sent < phase_end) random_burst();
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d words under reset and three register settings; %0d results checked.",
             words_sent, results_checked);
    $display("Input was held off for %0d cycles; %0d mismatches.",
             backpressure_cycles, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
